>>> hw/rtl/itp_pkg.sv
`default_nettype none
package itp_pkg;

    localparam int VALUE_W     = 16;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // infix token kinds as they arrive on the input
    typedef enum logic [2:0] {
        TOK_OPERAND = 3'd0,
        TOK_PLUS    = 3'd1,
        TOK_MINUS   = 3'd2,
        TOK_TIMES   = 3'd3,
        TOK_DIVIDE  = 3'd4,
        TOK_OPEN    = 3'd5,
        TOK_CLOSE   = 3'd6,
        TOK_END     = 3'd7
    } tok_kind_t;

    // codes held in the operator stack
    localparam logic [2:0] CODE_PLUS   = 3'd0;
    localparam logic [2:0] CODE_MINUS  = 3'd1;
    localparam logic [2:0] CODE_TIMES  = 3'd2;
    localparam logic [2:0] CODE_DIVIDE = 3'd3;
    localparam logic [2:0] CODE_OPEN   = 3'd4;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNMATCHED = 2'd2
    } err_t;

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } state_t;

    typedef struct packed {
        logic               carries_token;
        logic               is_operand;
        logic [VALUE_W-1:0] value;
        logic [1:0]         operator_code;
        logic               last_of_run;
        logic               end_of_expression;
        err_t               error_code;
    } result_t;

    // precedence of a stacked operator is at least that of another
    // (* and / share bit 1 set, + and - have it clear)
    function automatic logic prec_ge(input logic [2:0] a, input logic [2:0] b);
        prec_ge = (a[1] >= b[1]);
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/itp_ram.sv
`default_nettype none
module itp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/itp_ctrl.sv
`default_nettype none
module itp_ctrl
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_BITS  = 16,
    localparam int AW = $clog2(STACK_DEPTH)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire tok_kind_t          in_kind,
    input  wire logic [VALUE_W-1:0] in_value,
    output result_t                 res,
    output logic                    res_valid,
    input  wire logic               out_free,
    output logic                    mem_we,
    output logic [AW-1:0]           mem_waddr,
    output logic [2:0]              mem_wdata,
    output logic [AW-1:0]           mem_raddr,
    input  wire logic [2:0]         mem_rdata
);

    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int KEEP = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

    state_t                 state_reg, state_next;
    tok_kind_t              kind_reg;
    logic [KEEP-1:0]        value_reg;
    logic [2:0]             top_reg, top_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [RES_CNT_W-1:0]   nres_reg, nres_next;

    logic          has, below_has, full;
    logic [2:0]    below, op_code, push_code;
    logic          want, do_push, done, emit, advance;
    logic [CW-1:0] count_step;
    logic [2:0]    top_step;
    logic [CW-1:0] raddr_full;
    result_t       r;

    assign has       = (count_reg != '0);
    assign below_has = (count_reg >= CW'(2));
    assign full      = (count_reg >= CW'(STACK_DEPTH));
    assign below     = mem_rdata;
    assign op_code   = 3'(kind_reg - TOK_PLUS);

    always_comb begin
        want       = 1'b0;
        do_push    = 1'b0;
        push_code  = CODE_OPEN;
        done       = 1'b0;
        count_step = count_reg;
        top_step   = top_reg;
        r          = '0;
        r.error_code = ERR_NONE;

        case (kind_reg)
            TOK_OPERAND: begin
                want          = 1'b1;
                r.carries_token = 1'b1;
                r.is_operand  = 1'b1;
                r.value       = VALUE_W'(value_reg);
                r.last_of_run = 1'b1;
                done          = 1'b1;
            end
            TOK_PLUS, TOK_MINUS, TOK_TIMES, TOK_DIVIDE: begin
                if (has && top_reg != CODE_OPEN && prec_ge(top_reg, op_code)) begin
                    want            = 1'b1;
                    r.carries_token = 1'b1;
                    r.operator_code = top_reg[1:0];
                    // a push after a pop never overflows, so the stop decides last
                    r.last_of_run   = !below_has || below == CODE_OPEN ||
                                      !prec_ge(below, op_code);
                    count_step      = count_reg - CW'(1);
                    top_step        = below;
                end else begin
                    do_push   = 1'b1;
                    push_code = op_code;
                end
            end
            TOK_OPEN: begin
                do_push   = 1'b1;
                push_code = CODE_OPEN;
            end
            TOK_CLOSE: begin
                if (!has) begin
                    want          = 1'b1;
                    r.error_code  = ERR_UNMATCHED;
                    r.last_of_run = 1'b1;
                    count_step    = '0;
                    done          = 1'b1;
                end else if (top_reg == CODE_OPEN) begin
                    count_step = count_reg - CW'(1);
                    top_step   = below;
                    done       = 1'b1;
                end else begin
                    want            = 1'b1;
                    r.carries_token = 1'b1;
                    r.operator_code = top_reg[1:0];
                    r.last_of_run   = below_has && below == CODE_OPEN;
                    count_step      = count_reg - CW'(1);
                    top_step        = below;
                end
            end
            TOK_END: begin
                if (!has) begin
                    // bare marker only when the flush produced nothing
                    want                = (nres_reg == '0);
                    r.last_of_run       = 1'b1;
                    r.end_of_expression = 1'b1;
                    done                = 1'b1;
                end else if (top_reg == CODE_OPEN) begin
                    want                = 1'b1;
                    r.error_code        = ERR_UNMATCHED;
                    r.last_of_run       = 1'b1;
                    r.end_of_expression = 1'b1;
                    count_step          = '0;
                    done                = 1'b1;
                end else begin
                    want                = 1'b1;
                    r.carries_token     = 1'b1;
                    r.operator_code     = top_reg[1:0];
                    r.last_of_run       = !below_has;
                    r.end_of_expression = !below_has;
                    count_step          = count_reg - CW'(1);
                    top_step            = below;
                    done                = !below_has;
                end
            end
            default: begin
                done = 1'b1;
            end
        endcase

        if (do_push) begin
            done = 1'b1;
            if (full) begin
                want          = 1'b1;
                r.error_code  = ERR_OVERFLOW;
                r.last_of_run = 1'b1;
                count_step    = '0;
            end else begin
                count_step = count_reg + CW'(1);
                top_step   = push_code;
            end
        end

        // results past the limit are dropped, the last one kept closes the run
        emit = want && (nres_reg < RES_CNT_W'(MAX_RESULTS));
        if (nres_reg == RES_CNT_W'(MAX_RESULTS - 1)) begin
            r.last_of_run = 1'b1;
            if (kind_reg == TOK_END) begin
                r.end_of_expression = 1'b1;
            end
        end
    end

    assign advance = (state_reg == ST_WORK) && (!emit || out_free);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        top_next   = top_reg;
        nres_next  = nres_reg;
        in_ready   = 1'b0;
        mem_we     = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    nres_next  = '0;
                    state_next = ST_WORK;
                end
            end
            ST_WORK: begin
                if (advance) begin
                    count_next = count_step;
                    top_next   = top_step;
                    mem_we     = do_push && !full;
                    res_valid  = emit;
                    if (emit) begin
                        nres_next = nres_reg + RES_CNT_W'(1);
                    end
                    if (done) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res       = r;
    assign mem_waddr = count_reg[AW-1:0];
    assign mem_wdata = push_code;
    // keep the entry under the top on the read port; a push writes above it,
    // so the read and the write never meet on one entry
    assign raddr_full = count_next - CW'(2);
    assign mem_raddr  = raddr_full[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            nres_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            nres_reg  <= nres_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (in_valid && in_ready) begin
            kind_reg  <= in_kind;
            value_reg <= in_value[KEEP-1:0];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/infix_to_postfix_converter_top.sv
`default_nettype none
// Infix to postfix converter. Infix tokens enter one item at a time on the s_ side and the
// postfix form leaves on the m_ side, with tlast on the final result caused by each input item.
// The operator stack lives in a one-port-write, one-port-read RAM of STACK_DEPTH entries and
// needs no clearing after reset. Every item is first accepted and then worked one step at a
// time: an operand or an open parenthesis takes one step; an operator takes one step per
// stack entry it pops, plus one for its push; a close parenthesis takes one step per entry it
// pops, the open parenthesis included, plus one more for the error when no open parenthesis is
// found; end of expression takes one step per entry it flushes, an open parenthesis included,
// and one step on an empty stack. Each pop relies on the stack RAM read that fetches the next
// entry while the top is held in a register. A result waits in the output register while the
// next step goes on; a step that emits stalls only while that register still holds an item
// the receiver has not taken.
module infix_to_postfix_converter_top
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_BITS  = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // operand_value
    input  wire logic [2:0]  s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // value, operator_code, zero fill
    output logic             m_tlast,   // last_of_run
    output logic [4:0]       m_tuser    // carries_token, is_operand, end_of_expression,
                                        // error_code
);

    localparam int AW = $clog2(STACK_DEPTH);

    result_t       res, out_reg;
    logic          res_valid, m_valid_reg, out_free;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [2:0]    mem_wdata, mem_rdata;

    assign out_free = !m_valid_reg || m_tready;

    itp_ctrl #(
        .STACK_DEPTH(STACK_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (tok_kind_t'(s_tuser)),
        .in_value (s_tdata),
        .res      (res),
        .res_valid(res_valid),
        .out_free (out_free),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

    itp_ram #(
        .WIDTH(3),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, out_reg.operator_code, out_reg.value};
    assign m_tlast  = out_reg.last_of_run;
    assign m_tuser  = {out_reg.error_code, out_reg.end_of_expression,
                       out_reg.is_operand, out_reg.carries_token};

endmodule
`default_nettype wire
